[design/art_pkg.sv]
package art_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ID_W        = 32;
    localparam int TIME_W      = 32;
    localparam int RETRY_W     = 4;
    localparam int TIMEOUT_W   = 16;
    localparam int MEM_W       = TIME_W + RETRY_W;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [RETRY_W-1:0]   RETRY_RESET   = 4'd3;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_SCAN = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY   = 2'd1;

    typedef enum logic [2:0] {
        ACT_STORED  = 3'd0,
        ACT_FULL    = 3'd1,
        ACT_MATCHED = 3'd2,
        ACT_UNKNOWN = 3'd3,
        ACT_RESEND  = 3'd4,
        ACT_GIVEUP  = 3'd5,
        ACT_DONE    = 3'd6
    } action_t;

    typedef struct packed {
        logic [TABLE_DEPTH-1:0] hit_vec;
        logic                   hit;
        logic [IDX_W-1:0]       hit_idx;
        logic                   has_free;
        logic [IDX_W-1:0]       free_idx;
    } match_t;

endpackage

[design/ack_retransmit_tracker.sv]
// A send or unknown ack gives its result from ST_DECODE through the output register; a matched
// ack reads the memory and gives its result from ST_ACK_RES; a scan ends with an ACT_DONE result.
// Only one transaction is in flight: s_tready is high only in ST_IDLE. A scan reads one
// entry per cycle, but holds while a due entry waits for the output slot.
// Output backpressure adds its stall cycles. Reset (aresetn low, synchronous) clears
// all valid bits and the control state and loads a 2000 ms timeout and retry limit 3.
module ack_retransmit_tracker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // msg_id [31:0], now_ms [63:32]
    input  logic [art_pkg::IN_TDATA_W-1:0]  s_tdata,
    // kind [1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_id [31:0], attempt [35:32], zero [39:36]
    output logic [art_pkg::OUT_TDATA_W-1:0] m_tdata,
    // action [2:0]
    output logic [2:0]                      m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [art_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [art_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import art_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_DECODE  = 5'b00010,
        ST_ACK_RES = 5'b00100,
        ST_SCAN    = 5'b01000,
        ST_DONE    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [RETRY_W-1:0]   retry_limit_reg;

    logic [1:0]        kind_reg;
    logic [ID_W-1:0]   msg_id_reg;
    logic [TIME_W-1:0] now_reg;

    logic [TABLE_DEPTH-1:0] entry_valid_reg;
    logic [ID_W-1:0]        entry_id_reg [TABLE_DEPTH];
    logic [MEM_W-1:0]       mem [TABLE_DEPTH];
    logic [MEM_W-1:0]       rd_data_reg;

    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0] ack_idx_reg, ack_idx_next;

    logic                 out_valid_reg;
    action_t              out_action_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [RETRY_W-1:0]   out_attempt_reg;
    logic                 out_last_reg;

    logic               emit;
    action_t            e_action;
    logic [ID_W-1:0]    e_id;
    logic [RETRY_W-1:0] e_att;
    logic               e_last;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [MEM_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;

    logic               valid_set;
    logic               valid_clr;
    logic [IDX_W-1:0]   valid_idx;
    logic               id_we;
    logic [IDX_W-1:0]   slot_idx;

    logic               out_free;
    logic               accept;
    match_t             match;

    logic [TIME_W-1:0]  rd_time;
    logic [RETRY_W-1:0] rd_retries;
    logic [TIME_W-1:0]  elapsed;
    logic               due;
    logic               give_up;

    assign out_free   = !out_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    assign rd_time    = rd_data_reg[TIME_W-1:0];
    assign rd_retries = rd_data_reg[MEM_W-1:TIME_W];
    assign elapsed    = now_reg - rd_time;
    assign due        = entry_valid_reg[scan_idx_reg] &&
                        (elapsed > {{(TIME_W - TIMEOUT_W){1'b0}}, timeout_reg});
    assign give_up    = (rd_retries >= retry_limit_reg);

    art_match u_match (
        .valid_vec (entry_valid_reg),
        .ids       (entry_id_reg),
        .key       (msg_id_reg),
        .match     (match)
    );

    always_comb begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        ack_idx_next  = ack_idx_reg;
        emit          = 1'b0;
        e_action      = ACT_STORED;
        e_id          = '0;
        e_att         = '0;
        e_last        = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = scan_idx_reg;
        mem_wdata     = {RETRY_W'(rd_retries + RETRY_W'(1)), now_reg};
        mem_re        = 1'b0;
        mem_raddr     = scan_idx_reg;
        valid_set     = 1'b0;
        valid_clr     = 1'b0;
        valid_idx     = scan_idx_reg;
        id_we         = 1'b0;
        slot_idx      = match.hit ? match.hit_idx : match.free_idx;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    case (kind_reg)
                        KIND_SEND: begin
                            emit   = 1'b1;
                            e_id   = msg_id_reg;
                            e_last = 1'b1;
                            if (match.hit || match.has_free) begin
                                e_action  = ACT_STORED;
                                valid_set = 1'b1;
                                valid_idx = slot_idx;
                                id_we     = 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = slot_idx;
                                mem_wdata = {{RETRY_W{1'b0}}, now_reg};
                            end else begin
                                e_action = ACT_FULL;
                            end
                        end
                        KIND_ACK: begin
                            if (match.hit) begin
                                mem_re       = 1'b1;
                                mem_raddr    = match.hit_idx;
                                ack_idx_next = match.hit_idx;
                                state_next   = ST_ACK_RES;
                            end else begin
                                emit     = 1'b1;
                                e_action = ACT_UNKNOWN;
                                e_id     = msg_id_reg;
                                e_last   = 1'b1;
                            end
                        end
                        KIND_SCAN: begin
                            mem_re        = 1'b1;
                            mem_raddr     = '0;
                            scan_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ACK_RES: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_action   = ACT_MATCHED;
                    e_id       = msg_id_reg;
                    e_att      = rd_retries;
                    e_last     = 1'b1;
                    valid_clr  = 1'b1;
                    valid_idx  = ack_idx_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // hold the read data while a due entry waits for the output slot
                if (!due || out_free) begin
                    if (due) begin
                        emit = 1'b1;
                        e_id = entry_id_reg[scan_idx_reg];
                        if (give_up) begin
                            e_action  = ACT_GIVEUP;
                            e_att     = rd_retries;
                            valid_clr = 1'b1;
                        end else begin
                            e_action = ACT_RESEND;
                            e_att    = RETRY_W'(rd_retries + RETRY_W'(1));
                            mem_we   = 1'b1;
                        end
                    end
                    if (scan_idx_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                        state_next = ST_DONE;
                    end else begin
                        mem_re        = 1'b1;
                        mem_raddr     = IDX_W'(scan_idx_reg + IDX_W'(1));
                        scan_idx_next = IDX_W'(scan_idx_reg + IDX_W'(1));
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_action   = ACT_DONE;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            scan_idx_reg    <= '0;
            ack_idx_reg     <= '0;
            timeout_reg     <= TIMEOUT_RESET;
            retry_limit_reg <= RETRY_RESET;
            entry_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            ack_idx_reg  <= ack_idx_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_TIMEOUT) begin
                    timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                end else if (cfg_index == REG_RETRY) begin
                    retry_limit_reg <= cfg_data[RETRY_W-1:0];
                end
            end
            if (valid_set) begin
                entry_valid_reg[valid_idx] <= 1'b1;
            end else if (valid_clr) begin
                entry_valid_reg[valid_idx] <= 1'b0;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg   <= s_tuser;
            msg_id_reg <= s_tdata[ID_W-1:0];
            now_reg    <= s_tdata[IN_TDATA_W-1:ID_W];
        end
        if (id_we) begin
            entry_id_reg[slot_idx] <= msg_id_reg;
        end
        if (emit) begin
            out_action_reg  <= e_action;
            out_id_reg      <= e_id;
            out_attempt_reg <= e_att;
            out_last_reg    <= e_last;
        end
    end

    // time and retry memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_action_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_TDATA_W - ID_W - RETRY_W){1'b0}}, out_attempt_reg, out_id_reg};

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result overwrote a pending transaction");

    a_unique_id: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match.hit_vec))
        else $error("message id held in more than one slot");

    a_scan_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && (e_action == ACT_RESEND || e_action == ACT_GIVEUP) |-> !e_last)
        else $error("per-entry scan result marked last");

    a_giveup_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && e_action == ACT_GIVEUP |=> !entry_valid_reg[$past(scan_idx_reg)])
        else $error("given-up entry still valid");

    a_mem_ports: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("same-entry read and write in one cycle");

endmodule

[design/art_match.sv]
module art_match (
    input  logic [art_pkg::TABLE_DEPTH-1:0] valid_vec,
    input  logic [art_pkg::ID_W-1:0]        ids [art_pkg::TABLE_DEPTH],
    input  logic [art_pkg::ID_W-1:0]        key,
    output art_pkg::match_t                 match
);
    import art_pkg::*;

    logic [TABLE_DEPTH-1:0] hits;

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            hits[i] = valid_vec[i] && (ids[i] == key);
        end
    end

    // lowest matching slot and lowest free slot
    always_comb begin
        match.hit_vec  = hits;
        match.hit      = |hits;
        match.has_free = ~&valid_vec;
        match.hit_idx  = '0;
        match.free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (hits[i]) begin
                match.hit_idx = IDX_W'(i);
            end
            if (!valid_vec[i]) begin
                match.free_idx = IDX_W'(i);
            end
        end
    end

endmodule
